// ===== sv/spq_pkg.sv =====
package spq_pkg;

    localparam int unsigned CAPACITY_DEF = 16;

    // operation codes of the op field
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_ENQUEUED = 2'd0,
        STATUS_DEQUEUED = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    // one held entry
    typedef struct packed {
        logic signed [31:0] data;
        logic signed [31:0] prio;
    } entry_t;

endpackage

// ===== sv/sorted_priority_queue_unit.sv =====
// channel | handshake            | beat fields
// --------+----------------------+------------------------------------------
// in      | in_valid, in_stall   | op, entry_data, entry_priority
// out     | out_valid, out_stall | out_data, out_priority, status, occupancy
//
// results of a refused enqueue, an empty dequeue or an enqueue into an empty queue are
//   registered straight from idle; a dequeue answers from the head read state; other
//   enqueues step from the tail, moving each larger entry back one place, until the new entry is written
// one memory read port and one comparator walk the list one entry per cycle from the tail
// reset clears head, fill count and sequencer; entries at or beyond the count are never used
// in_stall is high while an item is at work or a result waits on a stalled output
module sorted_priority_queue_unit #(
    parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic signed [31:0] entry_data,
    input  logic signed [31:0] entry_priority,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_data,
    output logic signed [31:0] out_priority,
    output logic [1:0]         status,
    output logic [4:0]         occupancy
);
    import spq_pkg::*;

    // address width of the ring and width of the fill count
    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W:0] SUM_CAP = (CNT_W + 1)'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENQ_CMP,
        ST_ENQ_PUT,
        ST_DEQ_RD
    } state_t;

    // entries live in a ring; logical place 0 is the head
    entry_t mem [CAPACITY];

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    entry_t            new_entry_reg, new_entry_next;
    entry_t            rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    entry_t            out_entry_reg, out_entry_next;
    logic [1:0]        status_reg, status_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;

    logic              in_accept;
    logic              out_free;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;
    logic              move_back;

    // logical place to ring address
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
        if (sum >= SUM_CAP)
        begin
            sum = sum - SUM_CAP;
        end
        return sum[IDX_W-1:0];
    endfunction

    // output slot is free, or frees at this edge
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;

    // the one comparator: held entry goes back only if strictly larger, so ties stay ahead
    assign move_back = rd_data_reg.prio > new_entry_reg.prio;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        new_entry_next = new_entry_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_entry_next = out_entry_reg;
        status_next    = status_reg;
        occ_next       = occ_reg;
        rd_addr        = head_reg;
        mem_we         = 1'b0;
        mem_waddr      = phys(head_reg, idx_reg);
        mem_wdata      = new_entry_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (op == OP_DEQUEUE)
                begin
                    rd_addr = head_reg;
                end
                else
                begin
                    rd_addr = phys(head_reg, count_reg - CNT_ONE);
                end
                if (in_accept)
                begin
                    new_entry_next.data = entry_data;
                    new_entry_next.prio = entry_priority;
                    idx_next            = count_reg;
                    if (op == OP_DEQUEUE)
                    begin
                        if (count_reg == '0)
                        begin
                            out_valid_next = 1'b1;
                            out_entry_next = '0;
                            status_next    = STATUS_EMPTY;
                            occ_next       = count_reg;
                        end
                        else
                        begin
                            // head read is already on its way
                            head_next  = phys(head_reg, CNT_ONE);
                            count_next = count_reg - CNT_ONE;
                            state_next = ST_DEQ_RD;
                        end
                    end
                    else if (count_reg == CNT_FULL)
                    begin
                        out_valid_next = 1'b1;
                        out_entry_next = '0;
                        status_next    = STATUS_FULL;
                        occ_next       = count_reg;
                    end
                    else if (count_reg == '0)
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = head_reg;
                        mem_wdata.data  = entry_data;
                        mem_wdata.prio  = entry_priority;
                        count_next      = CNT_ONE;
                        out_valid_next  = 1'b1;
                        out_entry_next  = '0;
                        status_next     = STATUS_ENQUEUED;
                        occ_next        = CNT_ONE;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_ONE;
                        state_next = ST_ENQ_CMP;
                    end
                end
            end

            ST_ENQ_CMP:
            begin
                // fetch the entry one place closer to the head for the next cycle
                rd_addr   = phys(head_reg, idx_reg - CNT_TWO);
                mem_we    = 1'b1;
                mem_waddr = phys(head_reg, idx_reg);
                if (move_back)
                begin
                    mem_wdata = rd_data_reg;
                    idx_next  = idx_reg - CNT_ONE;
                    if (idx_reg == CNT_ONE)
                    begin
                        state_next = ST_ENQ_PUT;
                    end
                end
                else
                begin
                    mem_wdata      = new_entry_reg;
                    out_valid_next = 1'b1;
                    out_entry_next = '0;
                    status_next    = STATUS_ENQUEUED;
                    occ_next       = count_reg;
                    state_next     = ST_IDLE;
                end
            end

            ST_ENQ_PUT:
            begin
                // new entry becomes the head
                mem_we         = 1'b1;
                mem_waddr      = head_reg;
                mem_wdata      = new_entry_reg;
                out_valid_next = 1'b1;
                out_entry_next = '0;
                status_next    = STATUS_ENQUEUED;
                occ_next       = count_reg;
                state_next     = ST_IDLE;
            end

            ST_DEQ_RD:
            begin
                out_valid_next = 1'b1;
                out_entry_next = rd_data_reg;
                status_next    = STATUS_DEQUEUED;
                occ_next       = count_reg;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            new_entry_reg <= '0;
            out_valid_reg <= 1'b0;
            out_entry_reg <= '0;
            status_reg    <= STATUS_ENQUEUED;
            occ_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            new_entry_reg <= new_entry_next;
            out_valid_reg <= out_valid_next;
            out_entry_reg <= out_entry_next;
            status_reg    <= status_next;
            occ_reg       <= occ_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_data     = out_entry_reg.data;
    assign out_priority = out_entry_reg.prio;
    assign status       = status_reg;
    assign occupancy    = 5'(occ_reg);

    // fill count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_FULL)
        else $error("fill count beyond capacity");

    // while an item is at work no earlier result is still held
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !out_valid_reg)
        else $error("result pending while busy");

    // a refused enqueue leaves the queue as it was
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && op == OP_ENQUEUE && count_reg == CNT_FULL
        |=> count_reg == $past(count_reg) && head_reg == $past(head_reg)
            && out_valid_reg && status_reg == STATUS_FULL)
        else $error("full enqueue changed the queue");

    // a dequeue on a non-empty queue goes to the head read and shrinks by one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && op == OP_DEQUEUE && count_reg != '0
        |=> state_reg == ST_DEQ_RD && count_reg == $past(count_reg) - CNT_ONE)
        else $error("dequeue sequencing broken");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;

    import spq_pkg::*;

    localparam int unsigned DEPTH = CAPACITY_DEF;

    // one expected or observed result beat
    typedef struct {
        logic signed [31:0] data;
        logic signed [31:0] prio;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } answer_t;

    // mirror of the sorted list plus the answers still owed by the block
    class pq_scoreboard;
        entry_t      held[$];
        answer_t     pending_answers[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // work out the answer to one accepted input beat and queue it
        function void note_beat(logic beat_op, logic signed [31:0] d,
                                logic signed [31:0] p);
            answer_t     a;
            entry_t      e;
            int unsigned pos;
            a.data   = '0;
            a.prio   = '0;
            if (beat_op == OP_ENQUEUE)
            begin
                if (held.size() >= DEPTH)
                begin
                    a.status = STATUS_FULL;
                end
                else
                begin
                    // goes behind every entry of lower or equal priority, head too
                    pos = 0;
                    while (pos < held.size() && held[pos].prio <= p)
                        pos++;
                    e.data = d;
                    e.prio = p;
                    held.insert(pos, e);
                    a.status = STATUS_ENQUEUED;
                end
            end
            else
            begin
                if (held.size() == 0)
                begin
                    a.status = STATUS_EMPTY;
                end
                else
                begin
                    e = held.pop_front();
                    a.data   = e.data;
                    a.prio   = e.prio;
                    a.status = STATUS_DEQUEUED;
                end
            end
            a.occupancy = 5'(held.size());
            pending_answers.push_back(a);
        endfunction

        // compare one accepted result beat with the oldest expectation
        function void check_beat(answer_t got);
            answer_t want;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result beat with nothing expected: ",
                              "data %0d prio %0d status %0d occ %0d"},
                             got.data, got.prio, got.status, got.occupancy);
                return;
            end
            want = pending_answers.pop_front();
            if (got.data !== want.data || got.prio !== want.prio ||
                got.status !== want.status || got.occupancy !== want.occupancy)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected data %0d prio %0d status %0d occ %0d, ",
                              "got data %0d prio %0d status %0d occ %0d"},
                             want.data, want.prio, want.status, want.occupancy,
                             got.data, got.prio, got.status, got.occupancy);
            end
        endfunction

        function int unsigned outstanding();
            return pending_answers.size();
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic               op             = OP_ENQUEUE;
    logic signed [31:0] entry_data     = '0;
    logic signed [31:0] entry_priority = '0;
    logic               out_stall      = 1'b0;

    logic               in_stall;
    logic               out_valid;
    logic signed [31:0] out_data;
    logic signed [31:0] out_priority;
    logic [1:0]         status;
    logic [4:0]         occupancy;

    // idle odds in percent per cycle, changed by the main sequence
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    // cycles of forced output hold-off still to run
    int unsigned hold_left     = 0;

    pq_scoreboard sb = new();

    sorted_priority_queue_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .entry_data     (entry_data),
        .entry_priority (entry_priority),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .out_priority   (out_priority),
        .status         (status),
        .occupancy      (occupancy)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #400000;
        $display("sorted_priority_queue_unit test failed");
        $finish;
    end

    // receiver: checks every accepted result beat and drives out_stall
    // values read right after the edge are the ones the block sampled
    initial
    begin
        answer_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                got.data      = out_data;
                got.prio      = out_priority;
                got.status    = status;
                got.occupancy = occupancy;
                sb.check_beat(got);
            end
            if (hold_left != 0)
            begin
                // long hold-off so the block backs up into its input
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // offer one input beat from the current edge until it is taken,
    // then maybe leave a random gap; in_valid stays high if no gap follows
    task automatic send_item(input logic o, input logic signed [31:0] d,
                             input logic signed [31:0] p);
        int unsigned gap;
        in_valid       <= 1'b1;
        op             <= o;
        entry_data     <= d;
        entry_priority <= p;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_beat(o, d, p);
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender pauses until every owed result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // random beat; enq_pct biases toward filling or emptying the list
    task automatic send_random(input int unsigned enq_pct);
        logic               o;
        logic signed [31:0] d;
        logic signed [31:0] p;
        o = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
        d = $urandom;
        case ($urandom_range(0, 3))
            0: p = $urandom;
            // narrow range, lots of equal priorities
            1: p = $signed({29'd0, 3'($urandom_range(0, 7))}) - 32'sd4;
            2: p = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: p = $urandom_range(0, 40);
        endcase
        send_item(o, d, p);
    endtask

    // bursts that lean to enqueue or dequeue so full and empty both get hit
    task automatic random_phase(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        int unsigned enq_pct;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 2))
                0: enq_pct = 85;
                1: enq_pct = 15;
                default: enq_pct = 50;
            endcase
            burst = $urandom_range(8, 40);
            repeat (burst)
            begin
                if (sent < count)
                begin
                    send_random(enq_pct);
                    sent++;
                end
            end
        end
    endtask

    // main sequence
    initial
    begin
        int unsigned guard;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty dequeue, extremes, ties with the head, full list
        send_item(OP_DEQUEUE, 32'sd0, 32'sd0);
        send_item(OP_ENQUEUE, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(OP_ENQUEUE, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_ENQUEUE, -32'sd1, 32'sd0);
        send_item(OP_ENQUEUE, 32'sd1, 32'sd0);
        // equal to the head, must land behind it
        send_item(OP_ENQUEUE, 32'sd2, 32'h8000_0000);
        send_item(OP_ENQUEUE, 32'sd3, -32'sd1);
        send_item(OP_ENQUEUE, 32'sd4, 32'sd1);
        for (int i = 0; i < 9; i++)
            send_item(OP_ENQUEUE, 32'h5555_5555 ^ i, i - 4);
        // list holds sixteen, this one is refused
        send_item(OP_ENQUEUE, 32'haaaa_aaaa, 32'h8000_0000);
        repeat (3) send_item(OP_DEQUEUE, 32'hffff_ffff, 32'hffff_ffff);
        drain();

        // phase 1: sender idles a little, receiver a lot
        send_idle_pct = 14;
        recv_idle_pct = 48;
        random_phase(100);
        // output held off long enough that the block stalls its input
        hold_left = 200;
        random_phase(20);
        drain();
        random_phase(80);

        // phase 2: the other way round
        send_idle_pct = 48;
        recv_idle_pct = 14;
        random_phase(200);
        drain();

        // phase 3: no idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(200);

        // wait out the owed results, then a little longer for strays
        in_valid <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (sb.outstanding() != 0 && guard < 20000);
        repeat (DEPTH + 8) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("sorted_priority_queue_unit test passed");
        else
            $display("sorted_priority_queue_unit test failed");
        $finish;
    end

endmodule
